FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the flag-bit byte encoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define FBBE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FBBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FBBE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define FBBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hdl/fbbe_pkg.sv
// ----------------------------------------------------------------------------
// fbbe_pkg
// Shared types and constants of the flag-bit byte encoder.
// ----------------------------------------------------------------------------
package fbbe_pkg;

  // Request codes
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_END  = 1'b1;

  // Special byte values and their short codes
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [8:0] CODE_ZERO = 9'h000;  // bits 00
  localparam logic [8:0] CODE_ONES = 9'h001;  // bits 01
  localparam logic [8:0] CODE_TERM = 9'h100;  // 1 then eight zeros
  localparam logic [4:0] LEN_SHORT = 5'd2;
  localparam logic [4:0] LEN_LONG  = 5'd9;

  // Bit window: pending bits plus the longest code fit in two bytes
  localparam int unsigned WIN_W = 16;

  // Result queue
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_stream;
  } result_t;

  // What one accepted item produces
  typedef struct packed {
    logic [1:0] n_res;
    result_t    res0;
    result_t    res1;
    logic [7:0] acc_nxt;
    logic [2:0] fill_nxt;
  } pack_out_t;

endpackage

FILE: hdl/fbbe_pack.sv
// ----------------------------------------------------------------------------
// fbbe_pack
// Combinational bit packer: merges one code word into the pending bits.
// ----------------------------------------------------------------------------
module fbbe_pack import fbbe_pkg::*; (
  input  logic       req_type,
  input  logic [7:0] data_byte,
  input  logic [7:0] acc,
  input  logic [2:0] fill,
  output pack_out_t  po
);

  logic [8:0]       code;
  logic [4:0]       len;
  logic [4:0]       total;
  logic [4:0]       shamt;
  logic [WIN_W-1:0] win;

  always_comb begin
    if (req_type == REQ_END) begin
      code = CODE_TERM;
      len  = LEN_LONG;
    end else if (data_byte == BYTE_ZERO) begin
      code = CODE_ZERO;
      len  = LEN_SHORT;
    end else if (data_byte == BYTE_ONES) begin
      code = CODE_ONES;
      len  = LEN_SHORT;
    end else begin
      code = {1'b1, data_byte};
      len  = LEN_LONG;
    end
  end

  assign total = {2'b00, fill} + len;
  assign shamt = 5'(WIN_W) - total;
  assign win   = {acc, 8'h00} | ({{(WIN_W-9){1'b0}}, code} << shamt);

  always_comb begin
    po.res0.out_byte      = win[15:8];
    po.res0.end_of_stream = 1'b0;
    po.res1.out_byte      = win[7:0];
    po.res1.end_of_stream = (req_type == REQ_END);
    if (req_type == REQ_END || total >= 5'd16) begin
      // Two bytes out, nothing left pending
      po.n_res    = 2'd2;
      po.acc_nxt  = 8'h00;
      po.fill_nxt = 3'd0;
    end else if (total >= 5'd8) begin
      po.n_res    = 2'd1;
      po.acc_nxt  = win[7:0];
      po.fill_nxt = total[2:0];
    end else begin
      po.n_res    = 2'd0;
      po.acc_nxt  = win[15:8];
      po.fill_nxt = total[2:0];
    end
  end

endmodule

FILE: hdl/fbbe_queue.sv
// ----------------------------------------------------------------------------
// fbbe_queue
// Shifting result queue: two pushes and one pop per cycle, head at entry 0.
// ----------------------------------------------------------------------------
module fbbe_queue import fbbe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_cnt,
  input  result_t            push0,
  input  result_t            push1,
  input  logic               pop,
  output result_t            head,
  output logic [Q_CNT_W-1:0] count
);

  result_t            q_r   [Q_DEPTH];
  result_t            q_nxt [Q_DEPTH];
  logic [Q_CNT_W-1:0] cnt_r;
  logic [Q_CNT_W-1:0] cnt_nxt;
  logic [Q_CNT_W-1:0] base;

  assign base = cnt_r - Q_CNT_W'(pop);

  always_comb begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      // Shift down on pop, then drop new items behind the survivors
      if (pop && i < Q_DEPTH - 1) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (push_cnt != 2'd0 && Q_CNT_W'(i) == base) begin
        q_nxt[i] = push0;
      end
      if (push_cnt == 2'd2 && Q_CNT_W'(i) == base + Q_CNT_W'(1)) begin
        q_nxt[i] = push1;
      end
    end
    cnt_nxt = base + Q_CNT_W'(push_cnt);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Q_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign head  = q_r[0];
  assign count = cnt_r;

endmodule

FILE: hdl/flag_bit_byte_encoder.sv
// ----------------------------------------------------------------------------
// flag_bit_byte_encoder
// Packs a byte stream into a flag-bit coded bitstream, MSB first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one item is a request. req_type 0
//   carries a data byte: 0x00 codes as bits 00, 0xFF as 01, anything else as
//   a 1 and its eight bits. req_type 1 ends the stream: the terminator (1 and
//   eight zeros) is appended, the partial byte is padded with zeros and the
//   last byte leaves with end_of_stream set; the packer then starts empty.
//   Result channel (out_valid/out_ready): one packed byte per transfer.
//   Accepted items write their bytes into the registered result queue, and
//   out_out_byte shows its head. Throughput: an item yields up to two bytes
//   and the result side drains one byte per cycle while out_ready is high,
//   so a run of two-byte items is throttled by in_ready; items yielding one
//   or no byte go at one per cycle while out_ready is high. The four-entry
//   result queue sets this: in_ready is high while at most two are taken.
//   Stall: a low out_ready holds the head byte; the queue fills and in_ready
//   drops until room for two bytes is back.
//   Reset: rst_n (synchronous, active low) empties the queue and clears the
//   pending bits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module flag_bit_byte_encoder import fbbe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_out_byte,
  output logic       out_end_of_stream
);

  logic [7:0]         acc_r;
  logic [7:0]         acc_nxt;
  logic [2:0]         fill_r;
  logic [2:0]         fill_nxt;
  pack_out_t          po;
  result_t            head;
  logic [Q_CNT_W-1:0] q_count;
  logic               in_fire;
  logic               out_fire;

  // Accept only when the queue can take two more bytes
  assign in_ready = (q_count <= Q_CNT_W'(Q_DEPTH - 2));
  assign in_fire  = in_valid & in_ready;
  assign out_valid = (q_count != '0);
  assign out_fire  = out_valid & out_ready;

  fbbe_pack u_pack (
    .req_type  (in_req_type),
    .data_byte (in_data_byte),
    .acc       (acc_r),
    .fill      (fill_r),
    .po        (po)
  );

  fbbe_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (in_fire ? po.n_res : 2'd0),
    .push0    (po.res0),
    .push1    (po.res1),
    .pop      (out_fire),
    .head     (head),
    .count    (q_count)
  );

  // Advance the pending bits on every accepted item
  always_comb begin
    acc_nxt  = acc_r;
    fill_nxt = fill_r;
    if (in_fire) begin
      acc_nxt  = po.acc_nxt;
      fill_nxt = po.fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= 8'h00;
      fill_r <= 3'd0;
    end else begin
      acc_r  <= acc_nxt;
      fill_r <= fill_nxt;
    end
  end

  assign out_out_byte      = head.out_byte;
  assign out_end_of_stream = head.end_of_stream;

  // Checks
  `FBBE_ASSERT_NOW(a_room_on_accept, clk, rst_n, in_fire, q_count <= Q_CNT_W'(Q_DEPTH - 2), "item accepted without room for two bytes")
  `FBBE_ASSERT_NEXT(a_end_queues_two, clk, rst_n, in_fire && in_req_type == REQ_END, q_count >= Q_CNT_W'(2), "end of stream did not queue two bytes")
  `FBBE_ASSERT_NEXT(a_end_clears, clk, rst_n, in_fire && in_req_type == REQ_END, acc_r == 8'h00 && fill_r == 3'd0, "pending bits not cleared after end of stream")
  `FBBE_ASSERT_NOW(a_queue_bound, clk, rst_n, out_valid, q_count <= Q_CNT_W'(Q_DEPTH), "result queue overflow")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the flag-bit byte encoder.
// ----------------------------------------------------------------------------
// Drives request items over the input handshake. These are data bytes and
// end-of-stream markers. A scoreboard class predicts the packed bitstream
// bytes. Every accepted result byte is compared in order against that
// prediction. A directed pass covers the special byte codes and the
// terminator alignments. Random streams follow, under four phases of sender
// idling and receiver back-pressure. One phase also holds the receiver off
// for a long stretch.
// ----------------------------------------------------------------------------
module tb import fbbe_pkg::*;;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 10;

  // --------------------------------------------------------------------------
  // Scoreboard: bit packer mirror plus the queue of bytes still owed
  // --------------------------------------------------------------------------
  class bitstream_scoreboard;
    logic [7:0] pack_acc;
    logic [2:0] pack_fill;
    result_t    expected_bytes[$];
    int         mismatches;
    int         bytes_checked;
    int         n_requests;
    int         n_streams;
    int         n_zero;
    int         n_ones;
    int         n_literal;

    function new();
      pack_acc      = '0;
      pack_fill     = '0;
      mismatches    = 0;
      bytes_checked = 0;
      n_requests    = 0;
      n_streams     = 0;
      n_zero        = 0;
      n_ones        = 0;
      n_literal     = 0;
    endfunction

    // Append one bit from the top down; a full byte is owed to the output.
    function void push_bit(bit b);
      result_t r;
      if (b) pack_acc[3'd7 - pack_fill] = 1'b1;
      if (pack_fill == 3'd7) begin
        r.out_byte      = pack_acc;
        r.end_of_stream = 1'b0;
        expected_bytes.push_back(r);
        pack_acc  = '0;
        pack_fill = '0;
      end else begin
        pack_fill = pack_fill + 3'd1;
      end
    endfunction

    // Note an accepted request item and queue the bytes it produces.
    function void note_request(logic req, logic [7:0] data);
      result_t r;
      n_requests++;
      if (req == REQ_DATA) begin
        if (data == BYTE_ZERO) begin
          n_zero++;
          push_bit(1'b0);
          push_bit(1'b0);
        end else if (data == BYTE_ONES) begin
          n_ones++;
          push_bit(1'b0);
          push_bit(1'b1);
        end else begin
          n_literal++;
          push_bit(1'b1);
          for (int i = 7; i >= 0; i--) push_bit(data[i]);
        end
      end else begin
        n_streams++;
        // Terminator: a one and eight zeros
        push_bit(1'b1);
        for (int i = 0; i < 8; i++) push_bit(1'b0);
        // Flush the partial byte, zero padded
        if (pack_fill != 3'd0) begin
          r.out_byte      = pack_acc;
          r.end_of_stream = 1'b0;
          expected_bytes.push_back(r);
        end
        expected_bytes[expected_bytes.size() - 1].end_of_stream = 1'b1;
        pack_acc  = '0;
        pack_fill = '0;
      end
    endfunction

    // Compare one accepted result byte with the oldest expectation.
    function void check_byte(logic [7:0] got_byte, logic got_eos);
      result_t want;
      if (expected_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected byte %02h eos %0b", $realtime, got_byte, got_eos);
        return;
      end
      want = expected_bytes.pop_front();
      bytes_checked++;
      if (got_byte !== want.out_byte || got_eos !== want.end_of_stream) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] byte #%0d: expected %02h eos %0b, got %02h eos %0b",
                   $realtime, bytes_checked, want.out_byte, want.end_of_stream,
                   got_byte, got_eos);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_req_type = REQ_DATA;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_out_byte;
  logic       out_end_of_stream;

  always #CLK_HALF clk = ~clk;

  flag_bit_byte_encoder dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_out_byte      (out_out_byte),
    .out_end_of_stream (out_end_of_stream)
  );

  bitstream_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int cycle_count    = 0;

  // --------------------------------------------------------------------------
  // Watchdog: fail the run once the cycle limit is hit, whatever the progress
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d bytes still owed",
               cycle_count, sb.expected_bytes.size());
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: check every byte taken at a rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_byte(out_out_byte, out_end_of_stream);
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, or a long hold-off counted down here
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender tasks; every task starts and ends right after a falling edge
  // --------------------------------------------------------------------------

  // Offer one item and hold it until the DUT takes it.
  task automatic send_item(input logic req, input logic [7:0] data);
    // Drop valid for a random number of idle cycles first
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= req;
    in_data_byte <= data;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, data);
    @(negedge clk);
  endtask

  // Stop offering and wait until every owed byte has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(negedge clk);
  endtask

  // Random data byte, weighted toward the two short codes.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 20) return BYTE_ZERO;
    if (r < 40) return BYTE_ONES;
    return 8'($urandom_range(255));
  endfunction

  // Send roughly n items as streams of random length, mostly closed by an
  // end marker (whose data byte is random noise); a few streams run on.
  task automatic send_streams(input int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
      for (int i = 0; i < len; i++) begin
        send_item(REQ_DATA, pick_byte());
        sent++;
      end
      if ($urandom_range(9) != 0) begin
        send_item(REQ_END, 8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: end marker on an empty stream, data byte ignored
    send_item(REQ_END, 8'hA5);
    // Both short codes, literal extremes and alternating bit patterns
    send_item(REQ_DATA, BYTE_ZERO);
    send_item(REQ_DATA, BYTE_ONES);
    send_item(REQ_DATA, 8'h01);
    send_item(REQ_DATA, 8'h80);
    send_item(REQ_DATA, 8'h7F);
    send_item(REQ_DATA, 8'hFE);
    send_item(REQ_DATA, 8'hAA);
    send_item(REQ_DATA, 8'h55);
    send_item(REQ_END, 8'h00);
    // Seven bits pending, so the terminator fills the second byte exactly
    send_item(REQ_DATA, BYTE_ZERO);
    send_item(REQ_DATA, BYTE_ZERO);
    send_item(REQ_DATA, BYTE_ZERO);
    send_item(REQ_DATA, 8'h01);
    send_item(REQ_END, 8'hFF);
    // Byte-aligned stream: four short codes make one byte, then terminate
    send_item(REQ_DATA, BYTE_ONES);
    send_item(REQ_DATA, BYTE_ONES);
    send_item(REQ_DATA, BYTE_ONES);
    send_item(REQ_DATA, BYTE_ONES);
    send_item(REQ_END, 8'hFF);
    drain();

    // Phase 1: no idling, plus a long receiver hold-off while items keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_streams(150);
    hold_left = HOLD_CYCLES;
    send_streams(60);
    send_streams(140);
    drain();

    // Phase 2: sender idle most of the time
    send_idle_pct  = 64;
    recv_stall_pct = 0;
    send_streams(350);
    drain();

    // Phase 3: receiver stalling most of the time
    send_idle_pct  = 0;
    recv_stall_pct = 64;
    send_streams(350);
    drain();

    // Phase 4: both sides idle about a third of the time
    send_idle_pct  = 34;
    recv_stall_pct = 34;
    send_streams(400);

    // Wait out the owed bytes, then watch for strays
    drain();
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Ran %0d requests in %0d streams: %0d zero, %0d all-ones, %0d literal bytes",
             sb.n_requests, sb.n_streams, sb.n_zero, sb.n_ones, sb.n_literal);
    $display("Checked %0d result bytes, %0d mismatches, %0d still owed",
             sb.bytes_checked, sb.mismatches, sb.expected_bytes.size());
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/fbbe_pkg.sv
hdl/fbbe_pack.sv
hdl/fbbe_queue.sv
hdl/flag_bit_byte_encoder.sv
tb/tb.sv
